>>> sv/cht_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table package
// Shared types and constants for the separately chained keyed store.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned BucketsDefault = 64;
  localparam int unsigned EntriesDefault = 256;

  localparam int unsigned KeyW  = 31;
  localparam int unsigned CfgW  = 7;
  localparam int unsigned StatW = 3;
  localparam int unsigned BitW  = 5;

  localparam logic [CfgW-1:0] TableSizeReset = 7'd64;
  localparam logic [BitW-1:0] KeyTopBit      = 5'd30;

  typedef enum logic {
    OpInsert = 1'b0,
    OpLookup = 1'b1
  } op_e;

  typedef enum logic [StatW-1:0] {
    StatInserted = 3'd0,
    StatPresent  = 3'd1,
    StatFound    = 3'd2,
    StatNotFound = 3'd3,
    StatFull     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDiv,
    StHead,
    StPtr,
    StWalk,
    StNode,
    StDone
  } state_e;

endpackage

>>> sv/chained_hash_table.sv
// ----------------------------------------------------------------------------
// Chained hash table
// Keyed store with separate chaining: the bucket is the key modulo the
// configured table size, found by one shared subtractor from the top key bit down.
// One item is in flight at a time; the next input beat can be taken at the
// edge of the result beat, and a stalled result beat holds the next item in
// its completion step.
// After reset the bucket heads are cleared in turn, all BUCKETS of them
// (64 by default), during which input beats are stalled.
// ----------------------------------------------------------------------------
module chained_hash_table #(
  parameter int unsigned BUCKETS = cht_pkg::BucketsDefault,
  parameter int unsigned ENTRIES = cht_pkg::EntriesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cht_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic [cht_pkg::KeyW-1:0]  key_i,
  input  logic                      subscribed_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cht_pkg::StatW-1:0] status_o,
  output logic                      found_flag_o
);

  localparam int unsigned PtrW   = $clog2(ENTRIES + 1);
  localparam int unsigned NodeAw = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned BktW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned CfgW   = cht_pkg::CfgW;
  localparam int unsigned KeyW   = cht_pkg::KeyW;

  cht_pkg::state_e state_q, state_d;

  logic [CfgW-1:0]          cfg_q;
  logic [CfgW-1:0]          size;
  logic [BktW-1:0]          clr_q;
  logic [PtrW-1:0]          used_q;
  logic                     out_valid_q;
  cht_pkg::status_e         status_q, status_d;
  logic                     found_q, found_d;

  cht_pkg::op_e             op_q;
  logic [KeyW-1:0]          key_q;
  logic                     sub_q;
  logic [CfgW-1:0]          rem_q;
  logic [CfgW:0]            trial;
  logic [CfgW-1:0]          rem_d;
  logic [cht_pkg::BitW-1:0] bit_q;
  logic [PtrW-1:0]          ptr_q;
  logic [PtrW-1:0]          ptr_m1;
  logic [PtrW-1:0]          head_val_q;
  logic                     hit_q;
  logic                     flag_q;
  logic [BktW-1:0]          bucket;

  logic [PtrW-1:0]          head_mem [BUCKETS];
  logic [PtrW-1:0]          head_rd_q;
  logic [KeyW-1:0]          node_key_mem [ENTRIES];
  logic                     node_flag_mem [ENTRIES];
  logic [PtrW-1:0]          node_link_mem [ENTRIES];
  logic [KeyW-1:0]          node_key_q;
  logic                     node_flag_q;
  logic [PtrW-1:0]          node_link_q;

  logic                     accept;
  logic                     out_free;
  logic                     commit;
  logic                     full;
  logic                     match;
  logic                     do_insert;
  logic                     head_rd_en;
  logic                     head_we;
  logic [BktW-1:0]          head_wa;
  logic [PtrW-1:0]          head_wd;
  logic                     node_rd_en;

  always_comb begin
    if (cfg_q == '0) begin
      size = CfgW'(1);
    end else if (int'(cfg_q) > int'(BUCKETS)) begin
      size = CfgW'(BUCKETS);
    end else begin
      size = cfg_q;
    end
  end

  assign trial  = {rem_q, key_q[bit_q]};
  assign rem_d  = (trial >= {1'b0, size}) ? CfgW'(trial - {1'b0, size}) : CfgW'(trial);
  assign bucket = BktW'(rem_q);
  assign ptr_m1 = ptr_q - PtrW'(1);
  assign full   = (used_q == PtrW'(ENTRIES));
  assign match  = (node_key_q == key_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cht_pkg::StClear: begin
        if (clr_q == BktW'(BUCKETS - 1)) state_d = cht_pkg::StIdle;
      end
      cht_pkg::StIdle: begin
        if (in_valid_i) state_d = cht_pkg::StDiv;
      end
      cht_pkg::StDiv: begin
        if (bit_q == '0) state_d = cht_pkg::StHead;
      end
      cht_pkg::StHead: state_d = cht_pkg::StPtr;
      cht_pkg::StPtr:  state_d = cht_pkg::StWalk;
      cht_pkg::StWalk: begin
        state_d = (ptr_q == '0) ? cht_pkg::StDone : cht_pkg::StNode;
      end
      cht_pkg::StNode: begin
        state_d = match ? cht_pkg::StDone : cht_pkg::StWalk;
      end
      cht_pkg::StDone: begin
        if (out_free) state_d = cht_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != cht_pkg::StIdle);
    accept     = (state_q == cht_pkg::StIdle) && in_valid_i;
    head_rd_en = (state_q == cht_pkg::StHead);
    node_rd_en = (state_q == cht_pkg::StWalk) && (ptr_q != '0);
    commit     = (state_q == cht_pkg::StDone) && out_free;
    do_insert  = commit && (op_q == cht_pkg::OpInsert) && !hit_q && !full;
    head_we    = (state_q == cht_pkg::StClear) || do_insert;
    head_wa    = (state_q == cht_pkg::StClear) ? clr_q : bucket;
    head_wd    = (state_q == cht_pkg::StClear) ? '0 : used_q + PtrW'(1);
  end

  always_comb begin
    found_d = 1'b0;
    if (op_q == cht_pkg::OpInsert) begin
      priority if (hit_q) begin
        status_d = cht_pkg::StatPresent;
      end else if (full) begin
        status_d = cht_pkg::StatFull;
      end else begin
        status_d = cht_pkg::StatInserted;
      end
    end else if (hit_q) begin
      status_d = cht_pkg::StatFound;
      found_d  = flag_q;
    end else begin
      status_d = cht_pkg::StatNotFound;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cht_pkg::StClear;
      cfg_q       <= cht_pkg::TableSizeReset;
      clr_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_data_i;
      if (state_q == cht_pkg::StClear) clr_q <= clr_q + BktW'(1);
      if (do_insert) used_q <= used_q + PtrW'(1);
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= cht_pkg::op_e'(op_i);
      key_q <= key_i;
      sub_q <= subscribed_i;
      rem_q <= '0;
      bit_q <= cht_pkg::KeyTopBit;
      hit_q <= 1'b0;
    end
    if (state_q == cht_pkg::StDiv) begin
      rem_q <= rem_d;
      bit_q <= bit_q - cht_pkg::BitW'(1);
    end
    if (state_q == cht_pkg::StPtr) begin
      ptr_q      <= head_rd_q;
      head_val_q <= head_rd_q;
    end
    if (state_q == cht_pkg::StNode) begin
      if (match) begin
        hit_q  <= 1'b1;
        flag_q <= node_flag_q;
      end else begin
        ptr_q <= node_link_q;
      end
    end
    if (commit) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_rd_en) head_rd_q <= head_mem[bucket];
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      node_key_mem[used_q[NodeAw-1:0]]  <= key_q;
      node_flag_mem[used_q[NodeAw-1:0]] <= sub_q;
      node_link_mem[used_q[NodeAw-1:0]] <= head_val_q;
    end
    if (node_rd_en) begin
      node_key_q  <= node_key_mem[ptr_m1[NodeAw-1:0]];
      node_flag_q <= node_flag_mem[ptr_m1[NodeAw-1:0]];
      node_link_q <= node_link_mem[ptr_m1[NodeAw-1:0]];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign found_flag_o = found_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= PtrW'(ENTRIES))
    else $error("pool count exceeds the pool size");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> used_q != '0)
    else $error("insert did not take a node");

  a_walk_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cht_pkg::StWalk) |-> (ptr_q <= used_q))
    else $error("chain pointer reaches a node not yet written");

  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == cht_pkg::StDiv))
    else $error("accepted beat did not start the modulo");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == cht_pkg::StDone))
    else $error("result beat raised outside the completion step");

endmodule
